/* rtl/gmarl_pkg.sv */
// ----------------------------------------------------------------------------
// gmarl_pkg: shared types and constants
// Register map, reset values, mode and request codes used by the gimbal
// mode arbiter and rate limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package gmarl_pkg;

   // configuration register indexes (byte address is 4 * index)
   localparam logic [2:0] RegYawLow          = 3'd0;
   localparam logic [2:0] RegYawHigh         = 3'd1;
   localparam logic [2:0] RegPitchLow        = 3'd2;
   localparam logic [2:0] RegPitchHigh       = 3'd3;
   localparam logic [2:0] RegYawStepLimit    = 3'd4;
   localparam logic [2:0] RegPitchStepLimit  = 3'd5;
   localparam logic [2:0] RegConfidenceFloor = 3'd6;
   localparam logic [2:0] RegLossTicks       = 3'd7;

   // register reset values
   localparam logic signed [15:0] YawLowReset          = -16'sd9830;
   localparam logic signed [15:0] YawHighReset         = 16'sd9830;
   localparam logic signed [15:0] PitchLowReset        = -16'sd3277;
   localparam logic signed [15:0] PitchHighReset       = 16'sd2458;
   localparam logic [11:0]        YawStepLimitReset    = 12'd49;
   localparam logic [11:0]        PitchStepLimitReset  = 12'd41;
   localparam logic [7:0]         ConfidenceFloorReset = 8'd141;
   localparam logic [15:0]        LossTicksReset       = 16'd200;

   // vision older than this many ticks is stale
   localparam logic [7:0] VisionTimeoutTicks = 8'd10;

   // gimbal modes
   localparam logic ModeTracking  = 1'b0;
   localparam logic ModeDetecting = 1'b1;

   // mode request codes (code three means no request)
   localparam logic [1:0] ReqNone      = 2'd0;
   localparam logic [1:0] ReqTracking  = 2'd1;
   localparam logic [1:0] ReqDetecting = 2'd2;

   localparam logic [15:0] LossCountMax = 16'hFFFF;

   typedef struct packed {
      logic signed [15:0] yaw_low;
      logic signed [15:0] yaw_high;
      logic signed [15:0] pitch_low;
      logic signed [15:0] pitch_high;
      logic [11:0]        yaw_step_limit;
      logic [11:0]        pitch_step_limit;
      logic [7:0]         confidence_floor;
      logic [15:0]        loss_ticks;
   } cfg_type;

   typedef struct packed {
      logic mode;        // resulting gimbal mode
      logic use_vision;  // steer to the vision target this tick
   } mode_info_type;

endpackage : gmarl_pkg

`default_nettype wire

/* rtl/gimbal_mode_arbiter_rate_limiter_unit.sv */
// ----------------------------------------------------------------------------
// An accepted item is held in the input register, then in the result register.
// Throughput: one item per cycle unless rsp_stall holds the result register;
// the tick update is combinational logic between the input register and the
// result register, with state fed back.
// Reset (synchronous, active high): angles zero, mode tracking, loss counter
// cleared, registers at their defaults, no item held.
// ----------------------------------------------------------------------------
// gimbal_mode_arbiter_rate_limiter_unit: gimbal mode arbiter and rate limiter
// Per control tick selects the vision or motion target, clamps it to the
// angle limits and rate limits the angle change.
// ----------------------------------------------------------------------------
`default_nettype none

module gimbal_mode_arbiter_rate_limiter_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   // input items
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_motion_present,
   input  wire logic signed [15:0] req_motion_yaw,
   input  wire logic signed [15:0] req_motion_pitch,
   input  wire logic               req_vision_present,
   input  wire logic signed [15:0] req_vision_yaw,
   input  wire logic signed [15:0] req_vision_pitch,
   input  wire logic [7:0]         req_vision_confidence,
   input  wire logic [7:0]         req_vision_age,
   input  wire logic               req_vision_permitted,
   input  wire logic [1:0]         req_mode_request,
   // result items
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_yaw_out,
   output logic signed [15:0]      rsp_pitch_out,
   output logic signed [12:0]      rsp_yaw_step_out,
   output logic signed [12:0]      rsp_pitch_step_out,
   output logic                    rsp_mode_out,
   output logic                    rsp_yaw_limit_hit,
   output logic                    rsp_pitch_limit_hit,
   // configuration
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [4:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);
   import gmarl_pkg::*;

   cfg_type       cfg;
   mode_info_type mode_info;

   // input register
   logic               in_valid_ff, in_valid_in;
   logic               motion_present_ff;
   logic signed [15:0] motion_yaw_ff;
   logic signed [15:0] motion_pitch_ff;
   logic               vision_present_ff;
   logic signed [15:0] vision_yaw_ff;
   logic signed [15:0] vision_pitch_ff;
   logic [7:0]         vision_confidence_ff;
   logic [7:0]         vision_age_ff;
   logic               vision_permitted_ff;
   logic [1:0]         mode_request_ff;

   // result register
   logic               out_valid_ff, out_valid_in;
   logic signed [15:0] yaw_out_ff,  yaw_new;
   logic signed [15:0] pitch_out_ff, pitch_new;
   logic signed [12:0] yaw_step_ff,  yaw_step_new;
   logic signed [12:0] pitch_step_ff, pitch_step_new;
   logic               mode_out_ff;
   logic               yaw_hit_ff,  yaw_hit_new;
   logic               pitch_hit_ff, pitch_hit_new;

   logic advance;
   logic fire;
   logic req_take;

   // handshake: result register frees when empty or taken
   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   gmarl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   gmarl_mode u_mode (
      .clock             (clock),
      .reset             (reset),
      .enable            (fire),
      .cfg               (cfg),
      .vision_present    (vision_present_ff),
      .vision_confidence (vision_confidence_ff),
      .vision_age        (vision_age_ff),
      .vision_permitted  (vision_permitted_ff),
      .mode_request      (mode_request_ff),
      .mode_info         (mode_info)
   );

   gmarl_axis u_yaw (
      .clock          (clock),
      .reset          (reset),
      .enable         (fire),
      .use_vision     (mode_info.use_vision),
      .motion_present (motion_present_ff),
      .vision_angle   (vision_yaw_ff),
      .motion_angle   (motion_yaw_ff),
      .angle_low      (cfg.yaw_low),
      .angle_high     (cfg.yaw_high),
      .step_limit     (cfg.yaw_step_limit),
      .angle_new      (yaw_new),
      .step_new       (yaw_step_new),
      .limit_hit      (yaw_hit_new)
   );

   gmarl_axis u_pitch (
      .clock          (clock),
      .reset          (reset),
      .enable         (fire),
      .use_vision     (mode_info.use_vision),
      .motion_present (motion_present_ff),
      .vision_angle   (vision_pitch_ff),
      .motion_angle   (motion_pitch_ff),
      .angle_low      (cfg.pitch_low),
      .angle_high     (cfg.pitch_high),
      .step_limit     (cfg.pitch_step_limit),
      .angle_new      (pitch_new),
      .step_new       (pitch_step_new),
      .limit_hit      (pitch_hit_new)
   );

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input payload capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         motion_present_ff    <= req_motion_present;
         motion_yaw_ff        <= req_motion_yaw;
         motion_pitch_ff      <= req_motion_pitch;
         vision_present_ff    <= req_vision_present;
         vision_yaw_ff        <= req_vision_yaw;
         vision_pitch_ff      <= req_vision_pitch;
         vision_confidence_ff <= req_vision_confidence;
         vision_age_ff        <= req_vision_age;
         vision_permitted_ff  <= req_vision_permitted;
         mode_request_ff      <= req_mode_request;
      end
   end

   // result payload capture
   always_ff @(posedge clock) begin
      if (fire) begin
         yaw_out_ff    <= yaw_new;
         pitch_out_ff  <= pitch_new;
         yaw_step_ff   <= yaw_step_new;
         pitch_step_ff <= pitch_step_new;
         mode_out_ff   <= mode_info.mode;
         yaw_hit_ff    <= yaw_hit_new;
         pitch_hit_ff  <= pitch_hit_new;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_yaw_out         = yaw_out_ff;
   assign rsp_pitch_out       = pitch_out_ff;
   assign rsp_yaw_step_out    = yaw_step_ff;
   assign rsp_pitch_step_out  = pitch_step_ff;
   assign rsp_mode_out        = mode_out_ff;
   assign rsp_yaw_limit_hit   = yaw_hit_ff;
   assign rsp_pitch_limit_hit = pitch_hit_ff;

   // an empty input register never pushes back
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("input stalled with empty input register");

   // an item moved on produces a result next cycle
   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("processed item did not reach the result register");

   // an accepted item is held in the input register next cycle
   a_take_fills_input: assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_valid_ff)
      else $error("accepted item lost");

   // a held result that is not taken keeps its payload
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_yaw_out) &&
                                    $stable(rsp_mode_out)))
      else $error("stalled result changed");

endmodule : gimbal_mode_arbiter_rate_limiter_unit

`default_nettype wire

/* rtl/gmarl_csr.sv */
// ----------------------------------------------------------------------------
// gmarl_csr: configuration registers
// APB-style register file holding angle limits, step limits, vision
// confidence floor and the lost-vision fallback count.
// ----------------------------------------------------------------------------
`default_nettype none

module gmarl_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_psel,
   input  wire logic            csr_penable,
   input  wire logic            csr_pwrite,
   input  wire logic [4:0]      csr_paddr,
   input  wire logic [31:0]     csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output gmarl_pkg::cfg_type   cfg
);
   import gmarl_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            RegYawLow:          cfg_in.yaw_low          = csr_pwdata[15:0];
            RegYawHigh:         cfg_in.yaw_high         = csr_pwdata[15:0];
            RegPitchLow:        cfg_in.pitch_low        = csr_pwdata[15:0];
            RegPitchHigh:       cfg_in.pitch_high       = csr_pwdata[15:0];
            RegYawStepLimit:    cfg_in.yaw_step_limit   = csr_pwdata[11:0];
            RegPitchStepLimit:  cfg_in.pitch_step_limit = csr_pwdata[11:0];
            RegConfidenceFloor: cfg_in.confidence_floor = csr_pwdata[7:0];
            RegLossTicks:       cfg_in.loss_ticks       = csr_pwdata[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.yaw_low          <= YawLowReset;
         cfg_ff.yaw_high         <= YawHighReset;
         cfg_ff.pitch_low        <= PitchLowReset;
         cfg_ff.pitch_high       <= PitchHighReset;
         cfg_ff.yaw_step_limit   <= YawStepLimitReset;
         cfg_ff.pitch_step_limit <= PitchStepLimitReset;
         cfg_ff.confidence_floor <= ConfidenceFloorReset;
         cfg_ff.loss_ticks       <= LossTicksReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux, fields zero extended
   always_comb begin
      case (reg_idx)
         RegYawLow:          csr_prdata = {16'd0, cfg_ff.yaw_low};
         RegYawHigh:         csr_prdata = {16'd0, cfg_ff.yaw_high};
         RegPitchLow:        csr_prdata = {16'd0, cfg_ff.pitch_low};
         RegPitchHigh:       csr_prdata = {16'd0, cfg_ff.pitch_high};
         RegYawStepLimit:    csr_prdata = {20'd0, cfg_ff.yaw_step_limit};
         RegPitchStepLimit:  csr_prdata = {20'd0, cfg_ff.pitch_step_limit};
         RegConfidenceFloor: csr_prdata = {24'd0, cfg_ff.confidence_floor};
         RegLossTicks:       csr_prdata = {16'd0, cfg_ff.loss_ticks};
         default:            csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule : gmarl_csr

`default_nettype wire

/* rtl/gmarl_mode.sv */
// ----------------------------------------------------------------------------
// gmarl_mode: mode arbiter
// Tracks wanted and actual gimbal mode, judges vision validity and counts
// lost-vision ticks, falling back to tracking after the configured count.
// ----------------------------------------------------------------------------
`default_nettype none

module gmarl_mode (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 enable,
   input  wire gmarl_pkg::cfg_type   cfg,
   input  wire logic                 vision_present,
   input  wire logic [7:0]           vision_confidence,
   input  wire logic [7:0]           vision_age,
   input  wire logic                 vision_permitted,
   input  wire logic [1:0]           mode_request,
   output gmarl_pkg::mode_info_type  mode_info
);
   import gmarl_pkg::*;

   logic        gimbal_mode_ff, gimbal_mode_in;
   logic        wanted_mode_ff, wanted_mode_in;
   logic        loss_active_ff, loss_active_in;
   logic [15:0] loss_count_ff,  loss_count_in;
   logic        wanted_req;
   logic        mode_req;
   logic        vision_ok;
   logic        lost;
   logic        fall_back;

   always_comb begin
      // request first, then permission
      case (mode_request)
         ReqTracking:  wanted_req = ModeTracking;
         ReqDetecting: wanted_req = ModeDetecting;
         default:      wanted_req = wanted_mode_ff;
      endcase

      if (!vision_permitted)
         mode_req = ModeTracking;
      else if (wanted_req == ModeDetecting)
         mode_req = ModeDetecting;
      else
         mode_req = gimbal_mode_ff;

      vision_ok = vision_present && (vision_confidence >= cfg.confidence_floor) &&
                  (vision_age <= VisionTimeoutTicks);

      lost = (mode_req == ModeDetecting) && !vision_ok;

      // lost-vision counter, saturating
      if (!lost) begin
         loss_active_in = 1'b0;
         loss_count_in  = 16'd0;
      end else if (!loss_active_ff) begin
         loss_active_in = 1'b1;
         loss_count_in  = 16'd0;
      end else begin
         loss_active_in = 1'b1;
         loss_count_in  = (loss_count_ff == LossCountMax) ? loss_count_ff
                                                          : loss_count_ff + 16'd1;
      end

      fall_back      = lost && (loss_count_in >= cfg.loss_ticks);
      gimbal_mode_in = fall_back ? ModeTracking : mode_req;
      wanted_mode_in = fall_back ? ModeTracking : wanted_req;

      mode_info.mode       = gimbal_mode_in;
      mode_info.use_vision = (mode_req == ModeDetecting) && vision_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gimbal_mode_ff <= ModeTracking;
         wanted_mode_ff <= ModeTracking;
         loss_active_ff <= 1'b0;
         loss_count_ff  <= 16'd0;
      end else if (enable) begin
         gimbal_mode_ff <= gimbal_mode_in;
         wanted_mode_ff <= wanted_mode_in;
         loss_active_ff <= loss_active_in;
         loss_count_ff  <= loss_count_in;
      end
   end

endmodule : gmarl_mode

`default_nettype wire

/* rtl/gmarl_axis.sv */
// ----------------------------------------------------------------------------
// gmarl_axis: one gimbal axis
// Picks the target, clamps it to the angle limits, limits the per-tick step
// and holds the current angle.
// ----------------------------------------------------------------------------
`default_nettype none

module gmarl_axis (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               enable,
   input  wire logic               use_vision,
   input  wire logic               motion_present,
   input  wire logic signed [15:0] vision_angle,
   input  wire logic signed [15:0] motion_angle,
   input  wire logic signed [15:0] angle_low,
   input  wire logic signed [15:0] angle_high,
   input  wire logic [11:0]        step_limit,
   output logic signed [15:0]      angle_new,
   output logic signed [12:0]      step_new,
   output logic                    limit_hit
);

   logic signed [15:0] angle_ff, angle_in;
   logic signed [15:0] target;
   logic signed [15:0] raised;
   logic signed [15:0] clamped;
   logic signed [16:0] diff;
   logic signed [16:0] lim_pos;
   logic signed [16:0] lim_neg;
   logic signed [16:0] step;

   always_comb begin
      // target select: vision, motion, else hold
      if (use_vision)
         target = vision_angle;
      else if (motion_present)
         target = motion_angle;
      else
         target = angle_ff;

      // low limit first, so an inverted pair resolves to the high limit
      raised  = (target < angle_low) ? angle_low : target;
      clamped = (raised > angle_high) ? angle_high : raised;

      // step limit
      diff    = {clamped[15], clamped} - {angle_ff[15], angle_ff};
      lim_pos = {5'd0, step_limit};
      lim_neg = -lim_pos;
      if (diff < lim_neg)
         step = lim_neg;
      else if (diff > lim_pos)
         step = lim_pos;
      else
         step = diff;

      // the step moves toward an in-range target, so 16 bits suffice
      angle_in = angle_ff + step[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset)
         angle_ff <= '0;
      else if (enable)
         angle_ff <= angle_in;
   end

   assign angle_new = angle_in;
   assign step_new  = step[12:0];
   assign limit_hit = (angle_in == angle_low) || (angle_in == angle_high);

endmodule : gmarl_axis

`default_nettype wire

/* dv/gimbal_mode_arbiter_rate_limiter_unit_tb.sv */
// ----------------------------------------------------------------------------
// gimbal_mode_arbiter_rate_limiter_unit_tb: self-checking testbench
// Sends control ticks through the gimbal mode arbiter and rate limiter and
// checks every result item against a cycle-free model of the mode logic,
// the vision-loss counter, the angle clamps and the per-tick step limits.
// Runs directed ticks, then episodes of random ticks, over several register
// settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module gimbal_mode_arbiter_rate_limiter_unit_tb;

   import gmarl_pkg::*;

   localparam int         CycleLimit    = 200000;
   localparam int         DrainCycles   = 6;
   localparam int         HoldOffCycles = 400;
   localparam logic [1:0] ReqReserved   = 2'd3;

   typedef struct packed {
      logic               motion_present;
      logic signed [15:0] motion_yaw;
      logic signed [15:0] motion_pitch;
      logic               vision_present;
      logic signed [15:0] vision_yaw;
      logic signed [15:0] vision_pitch;
      logic [7:0]         vision_confidence;
      logic [7:0]         vision_age;
      logic               vision_permitted;
      logic [1:0]         mode_request;
   } gimbal_tick_type;

   typedef struct packed {
      logic signed [15:0] yaw;
      logic signed [15:0] pitch;
      logic signed [12:0] yaw_step;
      logic signed [12:0] pitch_step;
      logic               mode;
      logic               yaw_hit;
      logic               pitch_hit;
   } gimbal_result_type;

   typedef enum {VisGood, VisLost, VisAny} vision_kind_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #4 clock = ~clock;

   // block ports
   logic               req_valid             = 1'b0;
   logic               req_stall;
   logic               req_motion_present    = 1'b0;
   logic signed [15:0] req_motion_yaw        = '0;
   logic signed [15:0] req_motion_pitch      = '0;
   logic               req_vision_present    = 1'b0;
   logic signed [15:0] req_vision_yaw        = '0;
   logic signed [15:0] req_vision_pitch      = '0;
   logic [7:0]         req_vision_confidence = '0;
   logic [7:0]         req_vision_age        = '0;
   logic               req_vision_permitted  = 1'b0;
   logic [1:0]         req_mode_request      = ReqNone;
   logic               rsp_valid;
   logic               rsp_stall             = 1'b0;
   logic signed [15:0] rsp_yaw_out;
   logic signed [15:0] rsp_pitch_out;
   logic signed [12:0] rsp_yaw_step_out;
   logic signed [12:0] rsp_pitch_step_out;
   logic               rsp_mode_out;
   logic               rsp_yaw_limit_hit;
   logic               rsp_pitch_limit_hit;
   logic               csr_psel              = 1'b0;
   logic               csr_penable           = 1'b0;
   logic               csr_pwrite            = 1'b0;
   logic [4:0]         csr_paddr             = '0;
   logic [31:0]        csr_pwdata            = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   gimbal_mode_arbiter_rate_limiter_unit uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_motion_present    (req_motion_present),
      .req_motion_yaw        (req_motion_yaw),
      .req_motion_pitch      (req_motion_pitch),
      .req_vision_present    (req_vision_present),
      .req_vision_yaw        (req_vision_yaw),
      .req_vision_pitch      (req_vision_pitch),
      .req_vision_confidence (req_vision_confidence),
      .req_vision_age        (req_vision_age),
      .req_vision_permitted  (req_vision_permitted),
      .req_mode_request      (req_mode_request),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_yaw_out           (rsp_yaw_out),
      .rsp_pitch_out         (rsp_pitch_out),
      .rsp_yaw_step_out      (rsp_yaw_step_out),
      .rsp_pitch_step_out    (rsp_pitch_step_out),
      .rsp_mode_out          (rsp_mode_out),
      .rsp_yaw_limit_hit     (rsp_yaw_limit_hit),
      .rsp_pitch_limit_hit   (rsp_pitch_limit_hit),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   // pending ticks, expected results, bookkeeping
   gimbal_tick_type   tick_queue[$];
   gimbal_result_type gimbal_expected[$];
   gimbal_tick_type   offered;
   int             in_flight   = 0;
   int             error_count = 0;
   int             cycle_count = 0;
   int             gap_max     = 3;
   int             stall_max   = 3;
   int             hold_left   = 0;
   logic           hold_start  = 1'b0;

   // register mirror and tracked gimbal state
   cfg_type            cfg = '{YawLowReset, YawHighReset, PitchLowReset, PitchHighReset,
                               YawStepLimitReset, PitchStepLimitReset,
                               ConfidenceFloorReset, LossTicksReset};
   logic signed [15:0] yaw_pos    = '0;
   logic signed [15:0] pitch_pos  = '0;
   logic               cur_mode   = ModeTracking;
   logic               want_mode  = ModeTracking;
   logic               lost       = 1'b0;
   logic [15:0]        lost_ticks = '0;

   function automatic int clamp_to(int x, int lo, int hi);
      if (x < lo) x = lo;
      if (x > hi) x = hi;
      return x;
   endfunction

   // one control tick: mode update, loss counter, target pick, clamp, step limit
   task automatic advance_gimbal(input gimbal_tick_type t);
      logic              vision_ok;
      int                aim_yaw, aim_pitch, lim_yaw, lim_pitch;
      int                d_yaw, d_pitch, new_yaw, new_pitch;
      gimbal_result_type r;
      if (t.mode_request == ReqTracking) want_mode = ModeTracking;
      else if (t.mode_request == ReqDetecting) want_mode = ModeDetecting;
      if (!t.vision_permitted) cur_mode = ModeTracking;
      else if (want_mode == ModeDetecting) cur_mode = ModeDetecting;

      vision_ok = t.vision_present && (t.vision_confidence >= cfg.confidence_floor) &&
                  (t.vision_age <= VisionTimeoutTicks);

      // lost vision while detecting: count, fall back once the count is reached
      if (cur_mode == ModeDetecting && !vision_ok) begin
         if (!lost) begin
            lost = 1'b1;
            lost_ticks = '0;
         end else if (lost_ticks != LossCountMax) begin
            lost_ticks = lost_ticks + 16'd1;
         end
         if (lost_ticks >= cfg.loss_ticks) begin
            cur_mode = ModeTracking;
            want_mode = ModeTracking;
         end
      end else begin
         lost = 1'b0;
         lost_ticks = '0;
      end

      // target: vision, else motion, else hold
      aim_yaw = yaw_pos;
      aim_pitch = pitch_pos;
      if (cur_mode == ModeDetecting && vision_ok) begin
         aim_yaw = t.vision_yaw;
         aim_pitch = t.vision_pitch;
      end else if (t.motion_present) begin
         aim_yaw = t.motion_yaw;
         aim_pitch = t.motion_pitch;
      end
      aim_yaw = clamp_to(aim_yaw, $signed(cfg.yaw_low), $signed(cfg.yaw_high));
      aim_pitch = clamp_to(aim_pitch, $signed(cfg.pitch_low), $signed(cfg.pitch_high));

      lim_yaw = cfg.yaw_step_limit;
      lim_pitch = cfg.pitch_step_limit;
      d_yaw = clamp_to(aim_yaw - int'(yaw_pos), -lim_yaw, lim_yaw);
      d_pitch = clamp_to(aim_pitch - int'(pitch_pos), -lim_pitch, lim_pitch);
      new_yaw = int'(yaw_pos) + d_yaw;
      new_pitch = int'(pitch_pos) + d_pitch;
      yaw_pos = 16'(new_yaw);
      pitch_pos = 16'(new_pitch);

      r.yaw = 16'(new_yaw);
      r.pitch = 16'(new_pitch);
      r.yaw_step = 13'(d_yaw);
      r.pitch_step = 13'(d_pitch);
      r.mode = cur_mode;
      r.yaw_hit = (new_yaw == $signed(cfg.yaw_low)) || (new_yaw == $signed(cfg.yaw_high));
      r.pitch_hit = (new_pitch == $signed(cfg.pitch_low)) ||
                    (new_pitch == $signed(cfg.pitch_high));
      gimbal_expected.push_back(r);
   endtask

   // tick driver: offers queued ticks, random gap after each accepted item
   always @(posedge clock) begin : tick_driver
      gimbal_tick_type nxt;
      int              gap_left;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            advance_gimbal(offered);
            in_flight--;
         end
         if (gap_left != 0 || tick_queue.size() == 0) begin
            if (gap_left != 0) gap_left--;
            req_valid <= 1'b0;
         end else begin
            nxt = tick_queue.pop_front();
            offered = nxt;
            in_flight++;
            {req_motion_present, req_motion_yaw, req_motion_pitch, req_vision_present,
             req_vision_yaw, req_vision_pitch, req_vision_confidence, req_vision_age,
             req_vision_permitted, req_mode_request} <= nxt;
            req_valid <= 1'b1;
            gap_left = $urandom_range(0, gap_max);
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_start) hold_left <= HoldOffCycles;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   // result monitor: compare with the oldest expectation, random stall per item
   always @(posedge clock) begin : result_monitor
      gimbal_result_type want;
      int                stall_left;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (gimbal_expected.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("cycle %0d: result item with none expected, yaw %0d pitch %0d",
                           cycle_count, rsp_yaw_out, rsp_pitch_out);
            end else begin
               want = gimbal_expected.pop_front();
               if (want.yaw !== rsp_yaw_out || want.pitch !== rsp_pitch_out ||
                   want.yaw_step !== rsp_yaw_step_out ||
                   want.pitch_step !== rsp_pitch_step_out ||
                   want.mode !== rsp_mode_out || want.yaw_hit !== rsp_yaw_limit_hit ||
                   want.pitch_hit !== rsp_pitch_limit_hit) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("cycle %0d: expected yaw %0d pitch %0d dy %0d dp %0d mode %0b hit %0b%0b",
                              cycle_count, want.yaw, want.pitch, want.yaw_step,
                              want.pitch_step, want.mode, want.yaw_hit, want.pitch_hit);
                     $display("   actual   yaw %0d pitch %0d dy %0d dp %0d mode %0b hit %0b%0b",
                              rsp_yaw_out, rsp_pitch_out, rsp_yaw_step_out,
                              rsp_pitch_step_out, rsp_mode_out, rsp_yaw_limit_hit,
                              rsp_pitch_limit_hit);
                  end
               end
            end
            stall_left = $urandom_range(0, stall_max);
         end else if (stall_left != 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0) || (hold_left != 0);
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("gimbal_mode_arbiter_rate_limiter_unit test failed");
      $finish;
   end

   // register write: setup cycle, access cycle, done when pready seen
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         RegYawLow:          cfg.yaw_low = value[15:0];
         RegYawHigh:         cfg.yaw_high = value[15:0];
         RegPitchLow:        cfg.pitch_low = value[15:0];
         RegPitchHigh:       cfg.pitch_high = value[15:0];
         RegYawStepLimit:    cfg.yaw_step_limit = value[11:0];
         RegPitchStepLimit:  cfg.pitch_step_limit = value[11:0];
         RegConfidenceFloor: cfg.confidence_floor = value[7:0];
         default:            cfg.loss_ticks = value[15:0];
      endcase
   endtask

   task automatic load_config(input cfg_type c);
      write_reg(RegYawLow, 32'(c.yaw_low));
      write_reg(RegYawHigh, 32'(c.yaw_high));
      write_reg(RegPitchLow, 32'(c.pitch_low));
      write_reg(RegPitchHigh, 32'(c.pitch_high));
      write_reg(RegYawStepLimit, 32'(c.yaw_step_limit));
      write_reg(RegPitchStepLimit, 32'(c.pitch_step_limit));
      write_reg(RegConfidenceFloor, 32'(c.confidence_floor));
      write_reg(RegLossTicks, 32'(c.loss_ticks));
   endtask

   // block idle: nothing queued, offered or expected, then the pipeline empties
   task automatic wait_drain();
      while (tick_queue.size() != 0 || in_flight != 0 || gimbal_expected.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   function automatic gimbal_tick_type mk_tick(logic mp, logic signed [15:0] my,
                                               logic signed [15:0] mpt, logic vp,
                                               logic signed [15:0] vy,
                                               logic signed [15:0] vpt,
                                               logic [7:0] conf, logic [7:0] age,
                                               logic perm, logic [1:0] req);
      return '{mp, my, mpt, vp, vy, vpt, conf, age, perm, req};
   endfunction

   function automatic logic signed [15:0] rand_angle();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: begin
            case ($urandom_range(0, 3))
               0:       return 16'sh7FFF;
               1:       return 16'sh8000;
               2:       return 16'sh0000;
               default: return 16'shFFFF;
            endcase
         end
         default: return 16'($urandom_range(0, 24000) - 12000);
      endcase
   endfunction

   // random tick with vision forced good, forced lost, or random and often near the thresholds
   function automatic gimbal_tick_type rand_tick(vision_kind_type vk, logic perm,
                                                 logic [1:0] req);
      gimbal_tick_type t;
      t.motion_present = ($urandom_range(0, 4) != 0);
      t.motion_yaw = rand_angle();
      t.motion_pitch = rand_angle();
      t.vision_present = ($urandom_range(0, 4) != 0);
      t.vision_yaw = rand_angle();
      t.vision_pitch = rand_angle();
      t.vision_confidence = 8'($urandom);
      t.vision_age = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
      t.vision_permitted = perm;
      t.mode_request = req;
      case (vk)
         VisGood: begin
            t.vision_present = 1'b1;
            t.vision_confidence = 8'($urandom_range(cfg.confidence_floor, 255));
            t.vision_age = 8'($urandom_range(0, VisionTimeoutTicks));
         end
         VisLost: begin
            case ($urandom_range(0, 2))
               0: t.vision_present = 1'b0;
               1: begin
                  if (cfg.confidence_floor != 0)
                     t.vision_confidence = 8'($urandom_range(0, cfg.confidence_floor - 1));
                  else
                     t.vision_present = 1'b0;
               end
               default: t.vision_age = 8'($urandom_range(VisionTimeoutTicks + 1, 255));
            endcase
         end
         default: begin
            case ($urandom_range(0, 3))
               0: t.vision_age = 8'($urandom_range(VisionTimeoutTicks - 1,
                                                   VisionTimeoutTicks + 2));
               1: t.vision_confidence = (cfg.confidence_floor == 0) ? 8'd0 :
                                        cfg.confidence_floor - 8'd1;
               2: t.vision_confidence = cfg.confidence_floor;
               default: ;
            endcase
         end
      endcase
      return t;
   endfunction

   // episodes: acquire and track, runs of lost vision, single noise ticks
   task automatic run_random(input int n);
      int         made, kind, len;
      logic [1:0] req;
      made = 0;
      while (made < n) begin
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            len = $urandom_range(2, 12);
            tick_queue.push_back(rand_tick(VisGood, 1'b1, ReqDetecting));
            repeat (len) tick_queue.push_back(rand_tick(VisGood, 1'b1, ReqNone));
            made += len + 1;
         end else if (kind < 6) begin
            len = (cfg.loss_ticks < 30) ? $urandom_range(1, cfg.loss_ticks + 3) :
                                          $urandom_range(1, 30);
            repeat (len) tick_queue.push_back(rand_tick(VisLost, 1'b1, ReqNone));
            made += len;
         end else begin
            req = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(0, 3)) : ReqNone;
            tick_queue.push_back(rand_tick(VisAny, $urandom_range(0, 7) != 0, req));
            made++;
         end
      end
      wait_drain();
   endtask

   initial begin
      cfg_type c;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed ticks at the reset settings
      gap_max = 3;
      stall_max = 3;
      tick_queue.push_back(mk_tick(1, 32767, 32767, 0, 0, 0, 0, 0, 1, ReqNone));
      tick_queue.push_back(mk_tick(1, -32768, -32768, 0, 0, 0, 0, 0, 0, ReqNone));
      // no target at all: hold
      tick_queue.push_back(mk_tick(0, 0, 0, 0, 0, 0, 255, 0, 1, ReqNone));
      tick_queue.push_back(mk_tick(1, -2000, 300, 1, 5000, 1000, 255, 0, 1, ReqDetecting));
      // confidence at the floor and age at the timeout still count as valid
      tick_queue.push_back(mk_tick(1, -2000, 300, 1, 5000, 1000, ConfidenceFloorReset,
                                   VisionTimeoutTicks, 1, ReqNone));
      tick_queue.push_back(mk_tick(1, -2000, 300, 1, 5000, 1000, ConfidenceFloorReset - 8'd1,
                                   0, 1, ReqNone));
      tick_queue.push_back(mk_tick(1, -2000, 300, 1, 5000, 1000, 255,
                                   VisionTimeoutTicks + 8'd1, 1, ReqNone));
      tick_queue.push_back(mk_tick(1, -2000, 300, 1, 5000, 1000, 255, 0, 1, ReqNone));
      tick_queue.push_back(mk_tick(0, -2000, 300, 0, 5000, 1000, 255, 0, 1, ReqNone));
      // request code three is no request
      tick_queue.push_back(mk_tick(1, -2000, 300, 1, 5000, 1000, 255, 0, 1, ReqReserved));
      tick_queue.push_back(mk_tick(1, -2000, 300, 1, 5000, 1000, 255, 0, 0, ReqNone));
      tick_queue.push_back(mk_tick(1, -2000, 300, 1, 32767, -32768, 255, 0, 1, ReqNone));
      tick_queue.push_back(mk_tick(1, -2000, 300, 1, 5000, 1000, 255, 0, 1, ReqTracking));
      tick_queue.push_back(mk_tick(1, 4000, -700, 1, 5000, 1000, 255, 0, 1, ReqNone));
      wait_drain();

      // widest limits, largest steps, floor and loss count zero
      load_config('{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 12'hFFF, 12'hFFF,
                    8'd0, 16'd0});
      repeat (8) tick_queue.push_back(mk_tick(1, 32767, 32767, 0, 0, 0, 0, 0, 1, ReqNone));
      tick_queue.push_back(mk_tick(1, -32768, -32768, 0, 0, 0, 0, 0, 1, ReqNone));
      // loss count zero: falls back on the first lost tick
      tick_queue.push_back(mk_tick(0, 0, 0, 0, 100, 100, 255, 0, 1, ReqDetecting));
      tick_queue.push_back(mk_tick(0, 0, 0, 1, -32768, 32767, 0, 0, 1, ReqDetecting));
      wait_drain();
      gap_max = 15;
      stall_max = 15;
      run_random(100);

      // inverted limits: high limit wins; no idling on either side
      load_config('{16'sd1200, -16'sd1200, 16'sd700, -16'sd700, 12'd0, 12'hFFF,
                    8'hFF, 16'hFFFF});
      gap_max = 0;
      stall_max = 0;
      run_random(70);

      // random moderate settings with short loss counts
      for (int k = 0; k < 3; k++) begin
         c.yaw_low = 16'(0 - $urandom_range(0, 20000));
         c.yaw_high = 16'($urandom_range(0, 20000));
         c.pitch_low = 16'(0 - $urandom_range(0, 8000));
         c.pitch_high = 16'($urandom_range(0, 8000));
         c.yaw_step_limit = 12'($urandom_range(1, 800));
         c.pitch_step_limit = 12'($urandom_range(1, 800));
         c.confidence_floor = 8'($urandom);
         c.loss_ticks = 16'($urandom_range(0, 8));
         load_config(c);
         gap_max = (k == 1) ? 0 : 15;
         stall_max = (k == 0) ? 0 : 15;
         run_random(90);
      end

      // receiver holds off while ticks keep coming, so the input backs up
      gap_max = 0;
      stall_max = 0;
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      run_random(80);

      // back to the reset settings: a loss run long enough to fall back
      load_config('{YawLowReset, YawHighReset, PitchLowReset, PitchHighReset,
                    YawStepLimitReset, PitchStepLimitReset, ConfidenceFloorReset,
                    LossTicksReset});
      gap_max = 2;
      stall_max = 2;
      tick_queue.push_back(rand_tick(VisGood, 1'b1, ReqDetecting));
      repeat (205) tick_queue.push_back(rand_tick(VisLost, 1'b1, ReqNone));
      run_random(60);

      if (error_count == 0)
         $display("gimbal_mode_arbiter_rate_limiter_unit test passed");
      else
         $display("gimbal_mode_arbiter_rate_limiter_unit test failed");
      $finish;
   end

endmodule : gimbal_mode_arbiter_rate_limiter_unit_tb

`default_nettype wire

/* files.f */
rtl/gmarl_pkg.sv
rtl/gmarl_csr.sv
rtl/gmarl_mode.sv
rtl/gmarl_axis.sv
rtl/gimbal_mode_arbiter_rate_limiter_unit.sv
dv/gimbal_mode_arbiter_rate_limiter_unit_tb.sv
